### hdl/spf_pkg.sv
package spf_pkg;

	// value and table geometry
	localparam int VAL_W       = 16;
	localparam int MAX_VALUE   = 65535;
	localparam int TABLE_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);

	// sieve row index covers the square root of the largest value, plus one
	localparam int ROOT_W = VAL_W / 2 + 1;

	// results per value
	localparam int MAX_OUT = 15;
	localparam int CNT_W   = $clog2(MAX_OUT + 1);

	// divider: quotient bits per cycle and cycles per division
	localparam int DIV_STEPS  = 2;
	localparam int DIV_CYCLES = VAL_W / DIV_STEPS;
	localparam int DCNT_W     = $clog2(DIV_CYCLES);

	typedef enum logic [2:0] {
		S_FILL,
		S_PROBE,
		S_PCHECK,
		S_MARK,
		S_IDLE,
		S_FETCH,
		S_DIVIDE,
		S_EMIT
	} state_t;

endpackage

### hdl/spf_sieve_prime_factorizer_core.sv
// Prime factorizer backed by a smallest-prime-factor table.
// Request channel: drive value and pulse start while busy is low; the request
// is taken at that edge. Results come out on factor/last/error, each valid
// for exactly one cycle while strobe is high; the receiver cannot stall them.
// Factors arrive in ascending order, one per result, last marks the final.
// A value below 2 or above limit gives one result: factor 0, last 1, error 1,
// on the cycle after the request, and busy stays low.
// Each factor takes a table read, a 2-bit-per-cycle divider pass and one
// emit step; busy stays high from the request until the final emit step.
// Configuration: limit is written through cfg_valid/cfg_ready; cfg_ready is
// high only while idle with start low. A write rebuilds the table.
// Reset: limit returns to 65535 and the table is rebuilt. The rebuild fills
// the table and then sieves each prime up to the square root of limit;
// busy stays high and requests are held off meanwhile.
module spf_sieve_prime_factorizer_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [spf_pkg::VAL_W-1:0] value,
	output logic                      strobe,
	output logic [spf_pkg::VAL_W-1:0] factor,
	output logic                      last,
	output logic                      error,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [spf_pkg::VAL_W-1:0] limit
);

	localparam int VW    = spf_pkg::VAL_W;
	localparam int AW    = spf_pkg::ADDR_W;
	localparam int RW    = spf_pkg::ROOT_W;
	localparam int SQ_W  = 2 * RW;
	localparam int CW    = spf_pkg::CNT_W;
	localparam int DCW   = spf_pkg::DCNT_W;

	// control state
	spf_pkg::state_t state_q, state_d;
	logic [VW-1:0]   limit_q;
	logic [VW:0]     idx_q;
	logic [RW-1:0]   i_q;
	logic [VW:0]     j_q;
	logic            v_s1;
	logic [CW-1:0]   cnt_q;
	logic [DCW-1:0]  dcnt_q;
	logic            strobe_q;

	// payload
	logic [VW-1:0] factor_q;
	logic          last_q;
	logic          error_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] f_q;
	logic [VW-1:0] dq_q;
	logic [VW-1:0] dr_q;
	logic [VW:0]   j_s1;

	// table memory
	logic [VW-1:0] mem [spf_pkg::TABLE_DEPTH];
	logic [VW-1:0] rd_q;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [VW-1:0] mem_wdata;

	// derived values
	logic [VW-1:0]   lim;
	logic [SQ_W-1:0] sq;
	logic            cfg_fire;
	logic            in_fire;
	logic            in_range;
	logic            fill_more;
	logic            mark_issue;
	logic            mark_hit;
	logic            emit_last;
	logic [VW-1:0]   f_sel;
	logic [VW-1:0]   dq_n;
	logic [VW-1:0]   dr_n;

	// active limit, clamped to the table size
	assign lim = (limit_q > VW'(spf_pkg::MAX_VALUE)) ? VW'(spf_pkg::MAX_VALUE) : limit_q;

	assign sq         = {{RW{1'b0}}, i_q} * {{RW{1'b0}}, i_q};
	assign cfg_fire   = cfg_valid && cfg_ready;
	assign in_fire    = start && !busy;
	assign in_range   = (value >= VW'(2)) && (value <= lim);
	assign fill_more  = idx_q <= {1'b0, lim};
	assign mark_issue = j_q <= {1'b0, lim};
	assign mark_hit   = v_s1 && (rd_q == j_s1[VW-1:0]);
	assign emit_last  = (dq_q <= VW'(1)) || (cnt_q == CW'(spf_pkg::MAX_OUT - 1));
	assign f_sel      = (rd_q < VW'(2)) ? rem_q : rd_q;

	// divider: two restoring steps per cycle
	always_comb begin
		logic [VW:0] trial;
		dq_n = dq_q;
		dr_n = dr_q;
		for (int k = 0; k < spf_pkg::DIV_STEPS; k++) begin
			trial = {dr_n, dq_n[VW-1]};
			if (trial >= {1'b0, f_q}) begin
				trial = trial - {1'b0, f_q};
				dq_n  = {dq_n[VW-2:0], 1'b1};
			end else begin
				dq_n  = {dq_n[VW-2:0], 1'b0};
			end
			dr_n = trial[VW-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			spf_pkg::S_FILL: begin
				if (!fill_more) state_d = spf_pkg::S_PROBE;
			end
			spf_pkg::S_PROBE: begin
				if (sq > SQ_W'(lim)) state_d = spf_pkg::S_IDLE;
				else state_d = spf_pkg::S_PCHECK;
			end
			spf_pkg::S_PCHECK: begin
				if (rd_q == VW'(i_q)) state_d = spf_pkg::S_MARK;
				else state_d = spf_pkg::S_PROBE;
			end
			spf_pkg::S_MARK: begin
				if (!mark_issue) state_d = spf_pkg::S_PROBE;
			end
			spf_pkg::S_IDLE: begin
				if (cfg_fire) state_d = spf_pkg::S_FILL;
				else if (in_fire && in_range) state_d = spf_pkg::S_FETCH;
			end
			spf_pkg::S_FETCH: begin
				state_d = spf_pkg::S_DIVIDE;
			end
			spf_pkg::S_DIVIDE: begin
				if (dcnt_q == DCW'(spf_pkg::DIV_CYCLES - 1)) state_d = spf_pkg::S_EMIT;
			end
			spf_pkg::S_EMIT: begin
				if (emit_last) state_d = spf_pkg::S_IDLE;
				else state_d = spf_pkg::S_FETCH;
			end
			default: state_d = spf_pkg::S_IDLE;
		endcase
	end

	// outputs and memory control
	always_comb begin
		busy      = 1'b1;
		cfg_ready = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = rem_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q[AW-1:0];
		mem_wdata = idx_q[VW-1:0];
		case (state_q)
			spf_pkg::S_FILL: begin
				mem_we = fill_more;
			end
			spf_pkg::S_PROBE: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(i_q);
			end
			spf_pkg::S_MARK: begin
				mem_re    = mark_issue;
				mem_raddr = j_q[AW-1:0];
				mem_we    = mark_hit;
				mem_waddr = j_s1[AW-1:0];
				mem_wdata = VW'(i_q);
			end
			spf_pkg::S_IDLE: begin
				busy      = 1'b0;
				// a request takes the cycle ahead of a limit write
				cfg_ready = !start;
				mem_re    = start;
				mem_raddr = value;
			end
			spf_pkg::S_EMIT: begin
				mem_re    = 1'b1;
				mem_raddr = dq_q;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// table memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rd_q <= mem[mem_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= spf_pkg::S_FILL;
			limit_q  <= VW'(spf_pkg::MAX_VALUE);
			idx_q    <= (VW + 1)'(2);
			i_q      <= RW'(2);
			j_q      <= '0;
			v_s1     <= 1'b0;
			cnt_q    <= '0;
			dcnt_q   <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= 1'b0;
			case (state_q)
				spf_pkg::S_FILL: begin
					if (fill_more) idx_q <= idx_q + (VW + 1)'(1);
				end
				spf_pkg::S_PCHECK: begin
					if (rd_q == VW'(i_q)) j_q <= (VW + 1)'(sq);
					else i_q <= i_q + RW'(1);
				end
				spf_pkg::S_MARK: begin
					v_s1 <= mark_issue;
					if (mark_issue) j_q <= j_q + (VW + 1)'(i_q);
					else i_q <= i_q + RW'(1);
				end
				spf_pkg::S_IDLE: begin
					if (cfg_fire) begin
						limit_q <= limit;
						idx_q   <= (VW + 1)'(2);
						i_q     <= RW'(2);
					end else if (in_fire) begin
						strobe_q <= !in_range;
						cnt_q    <= '0;
					end
				end
				spf_pkg::S_FETCH: begin
					dcnt_q <= '0;
				end
				spf_pkg::S_DIVIDE: begin
					dcnt_q <= dcnt_q + DCW'(1);
				end
				spf_pkg::S_EMIT: begin
					strobe_q <= 1'b1;
					cnt_q    <= cnt_q + CW'(1);
				end
				default: begin
					v_s1 <= 1'b0;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		case (state_q)
			spf_pkg::S_IDLE: begin
				rem_q    <= value;
				factor_q <= '0;
				last_q   <= 1'b1;
				error_q  <= 1'b1;
			end
			spf_pkg::S_FETCH: begin
				f_q  <= f_sel;
				dq_q <= rem_q;
				dr_q <= '0;
			end
			spf_pkg::S_DIVIDE: begin
				dq_q <= dq_n;
				dr_q <= dr_n;
			end
			spf_pkg::S_EMIT: begin
				factor_q <= f_q;
				last_q   <= emit_last;
				error_q  <= 1'b0;
				rem_q    <= dq_q;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign strobe = strobe_q;
	assign factor = factor_q;
	assign last   = last_q;
	assign error  = error_q;

endmodule
